FILE: design/sle_pkg.sv
// sle_pkg: shared types and codes of the sorted list engine
// item structs for both channels, operation and status codes, sequencer
// states and the control word that drives the row of list cells
package sle_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned MAX_LANES = 8;

   // operation carried by a request item
   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_FIND   = 2'd2,
      FUNC_COUNT  = 2'd3
   } func_type;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      func_type                   func;
      logic signed [DATA_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [COUNT_W-1:0]   match_count;
      logic [COUNT_W-1:0]   list_size;
      logic [1:0]           status;
   } rsp_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TALLY,
      ST_APPLY
   } state_type;

   // control broadcast to every cell
   typedef struct packed {
      logic load;        // compare against key, latch flags and match tag
      logic shift_tag;   // move match tags down by one lane group
      logic do_insert;   // open a slot and drop the key in
      logic do_remove;   // close the slot of the first equal entry
   } cell_ctrl_type;

endpackage

FILE: design/sle_cell.sv
// sle_cell: one slot of the sorted list
// holds an entry, its compare flags and a match tag; uses sle_pkg
// trades entries with its neighbors on insert and remove
module sle_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  sle_pkg::cell_ctrl_type             ctrl,
   input  logic signed [sle_pkg::DATA_W-1:0]  key,
   input  logic                               valid,
   input  logic signed [sle_pkg::DATA_W-1:0]  left_entry,
   input  logic                               left_le,
   input  logic signed [sle_pkg::DATA_W-1:0]  right_entry,
   input  logic                               tag_upper,
   output logic signed [sle_pkg::DATA_W-1:0]  entry,
   output logic                               le_flag,
   output logic                               tag
);
   import sle_pkg::*;

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic                     lt_ff, lt_in;
   logic                     le_ff, le_in;
   logic                     tag_ff, tag_in;

   // flag capture, tag shifting and entry movement
   always_comb begin
      entry_in = entry_ff;
      lt_in    = lt_ff;
      le_in    = le_ff;
      tag_in   = tag_ff;
      if (ctrl.load) begin
         lt_in  = valid && (entry_ff < key);
         le_in  = valid && (entry_ff <= key);
         tag_in = valid && (entry_ff == key);
      end else if (ctrl.shift_tag) begin
         tag_in = tag_upper;
      end
      // entries above the insert point move up one slot
      if (ctrl.do_insert && !le_ff) begin
         entry_in = left_le ? key : left_entry;
      end
      // entries from the first match on move down one slot
      if (ctrl.do_remove && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   // flags
   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff  <= 1'b0;
         le_ff  <= 1'b0;
         tag_ff <= 1'b0;
      end else begin
         lt_ff  <= lt_in;
         le_ff  <= le_in;
         tag_ff <= tag_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry   = entry_ff;
   assign le_flag = le_ff;
   assign tag     = tag_ff;

endmodule

FILE: design/sle_tally.sv
// sle_tally: counts match tags as they leave the bottom of the cell row
// adds one lane group per cycle while run is high, over a fixed number of sweeps; uses sle_pkg
module sle_tally #(
   parameter int unsigned LANES   = 8,
   parameter int unsigned SWEEPS  = 8,
   parameter int unsigned COUNT_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 run,
   input  logic [LANES-1:0]     lane_tags,
   output logic [COUNT_W-1:0]   count,
   output logic                 done
);
   import sle_pkg::*;

   localparam int unsigned SWEEP_W = $clog2(SWEEPS + 1);

   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;
   logic [COUNT_W-1:0] pop;

   // ones in the current lane group
   always_comb begin
      pop = '0;
      for (int k = 0; k < LANES; k++) begin
         pop = pop + COUNT_W'(lane_tags[k]);
      end
   end

   // accumulator and sweep counter
   always_comb begin
      acc_in   = acc_ff;
      sweep_in = sweep_ff;
      if (start) begin
         acc_in   = '0;
         sweep_in = SWEEP_W'(SWEEPS - 1);
      end else if (run) begin
         acc_in   = acc_ff + pop;
         sweep_in = sweep_ff - SWEEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         sweep_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         sweep_ff <= sweep_in;
      end
   end

   assign count = acc_ff;
   assign done  = run && (sweep_ff == '0);

endmodule

FILE: design/sorted_list_engine.sv
// sorted_list_engine: bounded ascending list of signed 32-bit values
// top level: sequencer, row of sle_cell slots and sle_tally counter; uses sle_pkg
//
// Usage: a request item (req_valid/req_ready, req_data) names one operation:
// insert sorted, remove first equal, find or count equal. Each request yields
// exactly one result item (rsp_valid/rsp_ready, rsp_data) with found, the
// count of equal entries before the operation, the list size after it and a
// status (ok, insert dropped on a full list, remove found no match).
// On acceptance every cell compares its entry with the value at once. The
// match tags then drain out of the bottom of the row, LANES cells per cycle
// (LANES = min(8, CAPACITY)), so the count sweeps SWEEPS = CAPACITY / LANES
// lane groups, rounded up. The apply state then moves the entries and loads
// the result. A new item is taken only after the previous one has left the
// apply state, so the tag drain sets the pace. The result register frees
// the input side: the next item is accepted while a result waits, and the
// block holds in its apply state only if the previous result has not yet
// been taken. Reset empties the list; entry storage itself is not cleared.
module sorted_list_engine #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sle_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sle_pkg::rsp_type  rsp_data
);
   import sle_pkg::*;

   localparam int unsigned LANES  = (CAPACITY < MAX_LANES) ? CAPACITY : MAX_LANES;
   localparam int unsigned SWEEPS = (CAPACITY + LANES - 1) / LANES;
   localparam int unsigned FILL_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   req_type            req_ff;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               req_fire;
   logic               tally_run;
   logic               tally_done;
   logic               apply_fire;
   logic [FILL_W-1:0]  match_cnt;
   logic               found;
   logic               full;
   logic [FILL_W+COUNT_W-1:0] cnt_ext;
   logic [FILL_W+COUNT_W-1:0] fill_ext;
   logic [1:0]         status;

   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] key;

   logic signed [DATA_W-1:0] entry_w [CAPACITY];
   logic                     le_w    [CAPACITY];
   logic                     tag_w   [CAPACITY];
   logic [LANES-1:0]         lane_tags;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_TALLY;
         end
         ST_TALLY: begin
            if (tally_done) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      tally_run  = 1'b0;
      apply_fire = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready  = 1'b1;
         ST_TALLY: tally_run  = 1'b1;
         ST_APPLY: apply_fire = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // request holding register
   always_ff @(posedge clock) begin
      if (req_fire) req_ff <= req_data;
   end

   // operation decision
   assign found = (match_cnt != '0);
   assign full  = (fill_ff == FILL_W'(CAPACITY));
   assign key   = req_fire ? req_data.value : req_ff.value;

   always_comb begin
      ctrl.load      = req_fire;
      ctrl.shift_tag = tally_run;
      ctrl.do_insert = apply_fire && (req_ff.func == FUNC_INSERT) && !full;
      ctrl.do_remove = apply_fire && (req_ff.func == FUNC_REMOVE) && found;
   end

   // fill count and status
   always_comb begin
      fill_in = fill_ff;
      status  = STATUS_OK;
      case (req_ff.func)
         FUNC_INSERT: begin
            if (full) status  = STATUS_FULL;
            else      fill_in = fill_ff + FILL_W'(1);
         end
         FUNC_REMOVE: begin
            if (found) fill_in = fill_ff - FILL_W'(1);
            else       status  = STATUS_NOT_FOUND;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)           fill_ff <= '0;
      else if (apply_fire) fill_ff <= fill_in;
   end

   // result register
   assign cnt_ext  = {{COUNT_W{1'b0}}, match_cnt};
   assign fill_ext = {{COUNT_W{1'b0}}, fill_in};

   always_comb begin
      rsp_in.found       = found;
      rsp_in.match_count = cnt_ext[COUNT_W-1:0];
      rsp_in.list_size   = fill_ext[COUNT_W-1:0];
      rsp_in.status      = status;
      rsp_valid_in       = rsp_valid_ff;
      if (apply_fire)          rsp_valid_in = 1'b1;
      else if (rsp_ready)      rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (apply_fire) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // row of list cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic                     left_le;
      logic signed [DATA_W-1:0] right_entry;
      logic                     tag_upper;
      logic                     valid;

      if (i == 0) begin : g_first
         assign left_entry = entry_w[i];
         assign left_le    = 1'b1;
      end else begin : g_inner_left
         assign left_entry = entry_w[i-1];
         assign left_le    = le_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_inner_right
         assign right_entry = entry_w[i+1];
      end

      if (i + LANES < CAPACITY) begin : g_tag_feed
         assign tag_upper = tag_w[i+LANES];
      end else begin : g_tag_end
         assign tag_upper = 1'b0;
      end

      assign valid = (fill_ff > FILL_W'(i));

      sle_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key         (key),
         .valid       (valid),
         .left_entry  (left_entry),
         .left_le     (left_le),
         .right_entry (right_entry),
         .tag_upper   (tag_upper),
         .entry       (entry_w[i]),
         .le_flag     (le_w[i]),
         .tag         (tag_w[i])
      );
   end

   // bottom lane group feeds the counter
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      assign lane_tags[k] = tag_w[k];
   end

   sle_tally #(
      .LANES   (LANES),
      .SWEEPS  (SWEEPS),
      .COUNT_W (FILL_W)
   ) u_tally (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .run       (tally_run),
      .lane_tags (lane_tags),
      .count     (match_cnt),
      .done      (tally_done)
   );

endmodule

FILE: sim/sorted_list_engine_tb.sv
// sorted_list_engine_tb: self-checking testbench of the sorted list engine
// a shadow copy of the list predicts each result item; depends on sle_pkg and
// sorted_list_engine only
`timescale 1ns / 100ps

module sorted_list_engine_tb;
   import sle_pkg::*;

   localparam int LIST_DEPTH  = 64;
   localparam int CLK_PERIOD  = 10;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 30;
   localparam int CYCLE_LIMIT = 600000;
   localparam int POOL_MAX    = 6;
   localparam int REPORT_MAX  = 10;

   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND} traffic_mode_type;

   // one accepted request together with the result it must produce
   typedef struct {
      req_type req;
      rsp_type rsp;
   } outcome_type;

   // shadow list: predicts results and checks them in order
   class sorted_list_shadow;
      logic signed [DATA_W-1:0] entries [LIST_DEPTH];
      int unsigned              fill;
      outcome_type              awaited [$];
      int unsigned              mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      // apply one operation to the shadow list, return its result
      function rsp_type apply_op(req_type item);
         logic signed [DATA_W-1:0] key;
         int unsigned              hits;
         int unsigned              first_hit;
         int unsigned              slot;
         rsp_type                  res;
         key       = item.value;
         hits      = 0;
         first_hit = 0;
         slot      = 0;
         res       = '0;
         res.status = STATUS_OK;
         // lookup over the valid part of the list
         for (int i = 0; i < fill; i++) begin
            if (entries[i] == key) begin
               if (hits == 0)
                  first_hit = i;
               hits++;
            end
            if (entries[i] <= key)
               slot = i + 1;
         end
         res.found       = (hits != 0);
         res.match_count = hits[COUNT_W-1:0];
         case (item.func)
            FUNC_INSERT: begin
               if (fill == LIST_DEPTH) begin
                  res.status = STATUS_FULL;
               end else begin
                  for (int i = fill; i > slot; i--)
                     entries[i] = entries[i-1];
                  entries[slot] = key;
                  fill++;
               end
            end
            FUNC_REMOVE: begin
               if (hits == 0) begin
                  res.status = STATUS_NOT_FOUND;
               end else begin
                  for (int i = first_hit; i + 1 < fill; i++)
                     entries[i] = entries[i+1];
                  fill--;
               end
            end
            default: ;
         endcase
         res.list_size = fill[COUNT_W-1:0];
         return res;
      endfunction

      function void note_request(req_type item);
         outcome_type o;
         o.req = item;
         o.rsp = apply_op(item);
         awaited.push_back(o);
      endfunction

      function void check_response(rsp_type got);
         outcome_type o;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result item: found=%0b count=%0d size=%0d status=%0d",
                        got.found, got.match_count, got.list_size, got.status);
         end else begin
            o = awaited.pop_front();
            if (got.found !== o.rsp.found || got.match_count !== o.rsp.match_count ||
                got.list_size !== o.rsp.list_size || got.status !== o.rsp.status) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"mismatch on %s %0d: expected found=%0b count=%0d size=%0d ",
                            "status=%0d, got found=%0b count=%0d size=%0d status=%0d"},
                           o.req.func.name(), o.req.value,
                           o.rsp.found, o.rsp.match_count, o.rsp.list_size,
                           o.rsp.status,
                           got.found, got.match_count, got.list_size, got.status);
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function logic signed [DATA_W-1:0] pick_entry();
         return entries[$urandom_range(fill - 1)];
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   bit          hold_ask     = 1'b0;
   int          cycle_count  = 0;
   int          pool_size    = 1;
   logic signed [DATA_W-1:0] value_pool [POOL_MAX];

   sorted_list_shadow shadow;

   sorted_list_engine #(.CAPACITY(LIST_DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // watch both channels for accepted items
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            shadow.note_request(req_data);
         if (rsp_valid && rsp_ready)
            shadow.check_response(rsp_data);
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // offer one item, with random idle cycles ahead of it; valid stays high after
   task automatic send_item(req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0)
         @(posedge clock);
   endtask

   // one random operation shaped by the traffic mode
   function automatic req_type make_item(traffic_mode_type mode);
      req_type     item;
      int unsigned roll;
      roll = $urandom_range(99);
      case (mode)
         MIX_FILL:
            item.func = roll < 65 ? FUNC_INSERT : roll < 80 ? FUNC_REMOVE :
                        roll < 90 ? FUNC_FIND : FUNC_COUNT;
         MIX_DRAIN:
            item.func = roll < 15 ? FUNC_INSERT : roll < 75 ? FUNC_REMOVE :
                        roll < 88 ? FUNC_FIND : FUNC_COUNT;
         default:
            item.func = func_type'(roll[1:0]);
      endcase
      roll = $urandom_range(99);
      if (roll < 70)
         item.value = value_pool[$urandom_range(pool_size - 1)];
      else if (roll < 85 && shadow.fill != 0)
         item.value = shadow.pick_entry();
      else
         item.value = $urandom;
      return item;
   endfunction

   // episodes of fill, drain or mixed traffic, drawn mostly from a small set of values
   task automatic run_random(int count);
      int               sent;
      int unsigned      span;
      int unsigned      roll;
      traffic_mode_type mode;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(99);
         mode = roll < 45 ? MIX_FILL : roll < 75 ? MIX_DRAIN : MIX_BLEND;
         pool_size = $urandom_range(1, POOL_MAX);
         for (int k = 0; k < pool_size; k++) begin
            roll = $urandom_range(99);
            if (roll < 10)
               value_pool[k] = VALUE_MAX;
            else if (roll < 20)
               value_pool[k] = VALUE_MIN;
            else if (roll < 60)
               value_pool[k] = $urandom_range(40) - 20;
            else
               value_pool[k] = $urandom;
         end
         span = $urandom_range(40, 160);
         for (int k = 0; k < span && sent < count; k++) begin
            send_item(make_item(mode));
            sent++;
         end
      end
   endtask

   // result side held off while the request side keeps pushing
   task automatic stall_burst();
      int unsigned keep;
      keep         = req_idle_pct;
      req_idle_pct = 0;
      hold_ask     = 1'b1;
      repeat (24) send_item(make_item(MIX_BLEND));
      req_idle_pct = keep;
   endtask

   // extremes, every operation, empty-list and missing-value cases
   task automatic run_directed();
      send_item(req_type'{FUNC_FIND,   32'sd0});
      send_item(req_type'{FUNC_REMOVE, 32'sd0});
      send_item(req_type'{FUNC_COUNT,  -32'sd1});
      send_item(req_type'{FUNC_INSERT, VALUE_MAX});
      send_item(req_type'{FUNC_INSERT, VALUE_MIN});
      send_item(req_type'{FUNC_INSERT, 32'sd0});
      send_item(req_type'{FUNC_INSERT, -32'sd1});
      send_item(req_type'{FUNC_INSERT, 32'sd1});
      send_item(req_type'{FUNC_INSERT, 32'sd0});
      send_item(req_type'{FUNC_COUNT,  32'sd0});
      send_item(req_type'{FUNC_FIND,   VALUE_MAX});
      send_item(req_type'{FUNC_FIND,   VALUE_MIN});
      send_item(req_type'{FUNC_FIND,   32'sd5});
      send_item(req_type'{FUNC_REMOVE, 32'sd0});
      send_item(req_type'{FUNC_REMOVE, 32'sd12345});
      send_item(req_type'{FUNC_COUNT,  32'sd0});
      send_item(req_type'{FUNC_REMOVE, VALUE_MIN});
      send_item(req_type'{FUNC_REMOVE, VALUE_MAX});
      send_item(req_type'{FUNC_INSERT, 32'sh5555_5555});
      send_item(req_type'{FUNC_INSERT, 32'shAAAA_AAAA});
      send_item(req_type'{FUNC_COUNT,  32'shAAAA_AAAA});
      send_item(req_type'{FUNC_FIND,   32'sh5555_5555});
      send_item(req_type'{FUNC_REMOVE, -32'sd1});
      send_item(req_type'{FUNC_REMOVE, 32'sd1});
      send_item(req_type'{FUNC_REMOVE, 32'sd0});
   endtask

   // main sequence
   initial begin
      shadow = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      req_idle_pct = 27;
      rsp_idle_pct = 57;
      run_directed();
      stall_burst();
      run_random(615);
      wait_drained();

      // roles swapped
      req_idle_pct = 57;
      rsp_idle_pct = 27;
      run_random(615);
      wait_drained();

      // back to back
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(615);
      wait_drained();
      repeat (SETTLE) @(posedge clock);

      if (shadow.mismatches == 0 && shadow.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
design/sle_pkg.sv
design/sle_cell.sv
design/sle_tally.sv
design/sorted_list_engine.sv
sim/sorted_list_engine_tb.sv
